@@ rtl/lumsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lumsh_pkg
// Shared types, constants and the divider step for the lightness shifter.
// ----------------------------------------------------------------------------
package lumsh_pkg;

	localparam int NUM_CH        = 3;
	localparam int DIV_BITS      = 24;
	localparam int DIV_PER_STAGE = 4;
	localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;
	localparam int NUM_STAGES    = DIV_STAGES + 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [16:0] HALF_Q16 = 17'd32768;
	localparam logic [15:0] DEG60    = 16'd7680;
	localparam logic [15:0] DEG120   = 16'd15360;
	localparam logic [15:0] DEG180   = 16'd23040;
	localparam logic [15:0] DEG240   = 16'd30720;
	localparam logic [15:0] DEG360   = 16'd46080;
	localparam logic [8:0]  SUM_MAX  = 9'd510;

	// floor(y / 15) = (y * RECIP15) >> RECIP_SHIFT for y < 2**22
	localparam logic [22:0] RECIP15     = 23'd4473925;
	localparam int          RECIP_SHIFT = 26;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LUM_OFFSET = 3'd0,
		REG_KEY_ENABLE = 3'd1,
		REG_KEY_RED    = 3'd2,
		REG_KEY_GREEN  = 3'd3,
		REG_KEY_BLUE   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		HMAX_RED   = 2'd0,
		HMAX_GREEN = 2'd1,
		HMAX_BLUE  = 2'd2
	} hmax_t;

	typedef enum logic [1:0] {
		SEL_UP   = 2'd0,
		SEL_HIGH = 2'd1,
		SEL_DOWN = 2'd2,
		SEL_LOW  = 2'd3
	} seg_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       key;
		logic       mdfy;
		logic       grey;
	} cmn_t;

	typedef struct packed {
		logic [7:0]  rem;
		logic [23:0] num;
	} div_t;

	typedef struct packed {
		cmn_t        cmn;
		logic [16:0] nl;
		logic [7:0]  den;
		logic [7:0]  dvs;
		div_t        sa;
		div_t        hb;
	} dstage_t;

	typedef struct packed {
		cmn_t        cmn;
		logic [7:0]  gry;
		logic [16:0] m1;
		logic [17:0] m2;
	} post_t;

	// one restoring step: quotient bit enters at the bottom of num
	function automatic div_t div_step(input div_t d, input logic [7:0] dvs);
		logic [8:0] p;
		div_t       o;
		p     = {d.rem, d.num[23]};
		o.num = {d.num[22:0], 1'b0};
		if (p >= {1'b0, dvs}) begin
			o.rem    = 8'(p - {1'b0, dvs});
			o.num[0] = 1'b1;
		end else begin
			o.rem = p[7:0];
		end
		return o;
	endfunction

endpackage

@@ rtl/hls_luminance_shift.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_luminance_shift
// RGB -> HLS, signed lightness offset with clamp, HLS -> RGB; key colour bypass.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: red_in/green_in/blue_in on in_valid/in_ready.
//   Output beat: red_out/green_out/blue_out/key_match on out_valid/out_ready.
//   Config: cfg_we with cfg_index/cfg_wdata, to be written only while idle; not enforced.
//   Pipeline of 14 register stages, one pixel per cycle while the output is not held.
//   The depth is set by the two 24-step dividers (saturation and hue),
//   four steps per stage, plus the multiply chain of the back conversion.
//   Reset clears the config registers and every valid bit; no pixel is in flight.
//   When the receiver holds out_ready low with a beat waiting, the whole
//   pipeline holds and in_ready drops; nothing is lost or repeated.
//   Keyed pixels, zero offset and lightness already at the limit in the
//   direction of the offset pass the input pixel through unchanged.
// ----------------------------------------------------------------------------
module hls_luminance_shift (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          red_in,
	input  logic [7:0]                          green_in,
	input  logic [7:0]                          blue_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          red_out,
	output logic [7:0]                          green_out,
	output logic [7:0]                          blue_out,
	output logic                                key_match,
	input  logic                                cfg_we,
	input  logic [lumsh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lumsh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int NST = lumsh_pkg::NUM_STAGES;
	localparam int NDS = lumsh_pkg::DIV_STAGES;

	// config
	logic [15:0] lum_offset_q;
	logic        key_enable_q;
	logic [7:0]  key_red_q, key_green_q, key_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lum_offset_q <= '0;
			key_enable_q <= 1'b0;
			key_red_q    <= '0;
			key_green_q  <= '0;
			key_blue_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lumsh_pkg::REG_LUM_OFFSET: lum_offset_q <= cfg_wdata[15:0];
				lumsh_pkg::REG_KEY_ENABLE: key_enable_q <= cfg_wdata[0];
				lumsh_pkg::REG_KEY_RED:    key_red_q    <= cfg_wdata[7:0];
				lumsh_pkg::REG_KEY_GREEN:  key_green_q  <= cfg_wdata[7:0];
				lumsh_pkg::REG_KEY_BLUE:   key_blue_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// valid chain, global hold
	logic [NST:1] vld_s;
	logic         adv;

	assign adv      = !vld_s[NST] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:1], in_valid};
		end
	end

	// stage 1: max/min, key, bypass decision
	logic [7:0]        mx, mn, diff;
	logic [8:0]        sum;
	lumsh_pkg::hmax_t  hsel;
	lumsh_pkg::cmn_t   cmn_c;
	logic              off_pos, off_neg, key_hit;

	lumsh_pkg::cmn_t   cmn_s1;
	logic [7:0]        diff_s1;
	logic [8:0]        sum_s1;
	lumsh_pkg::hmax_t  hsel_s1;

	always_comb begin
		mx = (red_in > green_in) ? red_in : green_in;
		if (blue_in > mx) mx = blue_in;
		mn = (red_in < green_in) ? red_in : green_in;
		if (blue_in < mn) mn = blue_in;
		diff = mx - mn;
		sum  = {1'b0, mx} + {1'b0, mn};
		if (blue_in == mx) begin
			hsel = lumsh_pkg::HMAX_BLUE;
		end else if (green_in == mx) begin
			hsel = lumsh_pkg::HMAX_GREEN;
		end else begin
			hsel = lumsh_pkg::HMAX_RED;
		end
		key_hit = key_enable_q && red_in == key_red_q && green_in == key_green_q
			&& blue_in == key_blue_q;
		off_neg = lum_offset_q[15];
		off_pos = !lum_offset_q[15] && (lum_offset_q != '0);
		cmn_c.r    = red_in;
		cmn_c.g    = green_in;
		cmn_c.b    = blue_in;
		cmn_c.key  = key_hit;
		cmn_c.mdfy = !key_hit && ((off_pos && sum != lumsh_pkg::SUM_MAX)
			|| (off_neg && sum != 9'd0));
		cmn_c.grey = (diff == 8'd0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmn_s1  <= cmn_c;
			diff_s1 <= diff;
			sum_s1  <= sum;
			hsel_s1 <= hsel;
		end
	end

	// stage 2: lightness, new lightness, divider setup
	logic [15:0]        y2;
	logic [16:0]        lum;
	logic signed [18:0] nls;
	logic [16:0]        nl_c;
	logic [7:0]         den_c;
	logic [11:0]        t_c;
	logic [14:0]        n_c;
	lumsh_pkg::dstage_t dp_s [0:NDS];

	always_comb begin
		y2  = {sum_s1, 7'b0};
		lum = 17'(y2) + 17'((17'(y2) + 17'd1 + 17'(sum_s1[8:1])) >> 8);
		nls = $signed({2'b00, lum}) + $signed({{2{lum_offset_q[15]}}, lum_offset_q, 1'b0});
		if (nls < 0) begin
			nl_c = '0;
		end else if (nls > $signed({2'b00, lumsh_pkg::ONE_Q16})) begin
			nl_c = lumsh_pkg::ONE_Q16;
		end else begin
			nl_c = nls[16:0];
		end
		den_c = (sum_s1 <= 9'd255) ? sum_s1[7:0] : 8'(lumsh_pkg::SUM_MAX - sum_s1);
		case (hsel_s1)
			lumsh_pkg::HMAX_BLUE:
				t_c = 12'({diff_s1, 2'b0}) + 12'(cmn_s1.r) - 12'(cmn_s1.g);
			lumsh_pkg::HMAX_GREEN:
				t_c = 12'({diff_s1, 1'b0}) + 12'(cmn_s1.b) - 12'(cmn_s1.r);
			default:
				t_c = 12'({diff_s1, 2'b0}) + 12'({diff_s1, 1'b0})
					+ 12'(cmn_s1.g) - 12'(cmn_s1.b);
		endcase
		n_c = 15'({t_c[10:0], 4'b0}) - 15'(t_c[10:0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s[0].cmn    <= cmn_s1;
			dp_s[0].nl     <= nl_c;
			dp_s[0].den    <= den_c;
			dp_s[0].dvs    <= diff_s1;
			dp_s[0].sa.rem <= '0;
			dp_s[0].sa.num <= {diff_s1, 16'b0};
			dp_s[0].hb.rem <= '0;
			dp_s[0].hb.num <= {n_c, 9'b0};
		end
	end

	// stages 3..8: saturation and hue dividers
	lumsh_pkg::dstage_t dnx [0:NDS-1];

	for (genvar gi = 0; gi < NDS; gi++) begin : g_div
		always_comb begin
			dnx[gi] = dp_s[gi];
			for (int j = 0; j < lumsh_pkg::DIV_PER_STAGE; j++) begin
				dnx[gi].sa = lumsh_pkg::div_step(dnx[gi].sa, dnx[gi].den);
				dnx[gi].hb = lumsh_pkg::div_step(dnx[gi].hb, dnx[gi].dvs);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dp_s[gi+1] <= dnx[gi];
			end
		end
	end

	// stage 9: hue wrap, L*S
	logic [15:0]     hraw, hue_c;
	logic [33:0]     ls_full;
	lumsh_pkg::cmn_t cmn_s9;
	logic [16:0]     nl_s9, sat_s9, prod_s9;
	logic [15:0]     hue_s9;

	always_comb begin
		hraw    = dp_s[NDS].hb.num[15:0];
		hue_c   = (hraw > lumsh_pkg::DEG360) ? hraw - lumsh_pkg::DEG360 : hraw;
		ls_full = 34'(dp_s[NDS].nl) * 34'(dp_s[NDS].sa.num[16:0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmn_s9  <= dp_s[NDS].cmn;
			nl_s9   <= dp_s[NDS].nl;
			sat_s9  <= dp_s[NDS].sa.num[16:0];
			hue_s9  <= hue_c;
			prod_s9 <= ls_full[32:16];
		end
	end

	// stage 10: M1/M2, per channel hue segment
	logic [17:0]         m2_c, span_c;
	logic signed [18:0]  m1s;
	logic [16:0]         m1_c;
	logic [24:0]         gw;
	logic [7:0]          gry_c;
	logic signed [17:0]  hc [lumsh_pkg::NUM_CH];
	logic signed [17:0]  hofs [lumsh_pkg::NUM_CH];
	lumsh_pkg::seg_t     sel_c [lumsh_pkg::NUM_CH];
	logic [12:0]         fac_c [lumsh_pkg::NUM_CH];

	lumsh_pkg::post_t    pp_s10;
	logic [17:0]         span_s10;
	lumsh_pkg::seg_t     sel_s10 [lumsh_pkg::NUM_CH];
	logic [12:0]         fac_s10 [lumsh_pkg::NUM_CH];

	always_comb begin
		hofs[0] = 18'(lumsh_pkg::DEG120);
		hofs[1] = '0;
		hofs[2] = -18'(lumsh_pkg::DEG120);
		if (nl_s9 <= lumsh_pkg::HALF_Q16) begin
			m2_c = 18'(nl_s9) + 18'(prod_s9);
		end else begin
			m2_c = 18'(nl_s9) + 18'(sat_s9) - 18'(prod_s9);
		end
		m1s    = $signed({1'b0, nl_s9, 1'b0}) - $signed({1'b0, m2_c});
		m1_c   = (m1s < 0) ? 17'd0 : m1s[16:0];
		span_c = m2_c - 18'(m1_c);
		gw     = {nl_s9, 8'b0} - 25'(nl_s9);
		gry_c  = (gw[24:16] > 9'd255) ? 8'd255 : gw[23:16];
		for (int c = 0; c < lumsh_pkg::NUM_CH; c++) begin
			hc[c] = $signed({2'b00, hue_s9}) + hofs[c];
			if (hc[c] > $signed({2'b00, lumsh_pkg::DEG360})) begin
				hc[c] = hc[c] - $signed({2'b00, lumsh_pkg::DEG360});
			end else if (hc[c] < 0) begin
				hc[c] = hc[c] + $signed({2'b00, lumsh_pkg::DEG360});
			end
			if (hc[c] < $signed({2'b00, lumsh_pkg::DEG60})) begin
				sel_c[c] = lumsh_pkg::SEL_UP;
				fac_c[c] = hc[c][12:0];
			end else if (hc[c] < $signed({2'b00, lumsh_pkg::DEG180})) begin
				sel_c[c] = lumsh_pkg::SEL_HIGH;
				fac_c[c] = '0;
			end else if (hc[c] < $signed({2'b00, lumsh_pkg::DEG240})) begin
				sel_c[c] = lumsh_pkg::SEL_DOWN;
				fac_c[c] = 13'(lumsh_pkg::DEG240 - hc[c][15:0]);
			end else begin
				sel_c[c] = lumsh_pkg::SEL_LOW;
				fac_c[c] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s10.cmn <= cmn_s9;
			pp_s10.gry <= gry_c;
			pp_s10.m1  <= m1_c;
			pp_s10.m2  <= m2_c;
			span_s10   <= span_c;
			sel_s10    <= sel_c;
			fac_s10    <= fac_c;
		end
	end

	// stage 11: span * hue fraction
	lumsh_pkg::post_t pp_s11;
	lumsh_pkg::seg_t  sel_s11 [lumsh_pkg::NUM_CH];
	logic [30:0]      x_s11 [lumsh_pkg::NUM_CH];

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s11  <= pp_s10;
			sel_s11 <= sel_s10;
			for (int c = 0; c < lumsh_pkg::NUM_CH; c++) begin
				x_s11[c] <= 31'(span_s10) * 31'(fac_s10[c]);
			end
		end
	end

	// stage 12: divide by 7680 as shift and reciprocal of 15
	lumsh_pkg::post_t pp_s12;
	lumsh_pkg::seg_t  sel_s12 [lumsh_pkg::NUM_CH];
	logic [44:0]      rp [lumsh_pkg::NUM_CH];
	logic [18:0]      q_s12 [lumsh_pkg::NUM_CH];

	always_comb begin
		for (int c = 0; c < lumsh_pkg::NUM_CH; c++) begin
			rp[c] = 45'(x_s11[c][30:9]) * 45'(lumsh_pkg::RECIP15);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s12  <= pp_s11;
			sel_s12 <= sel_s11;
			for (int c = 0; c < lumsh_pkg::NUM_CH; c++) begin
				q_s12[c] <= rp[c][lumsh_pkg::RECIP_SHIFT +: 19];
			end
		end
	end

	// stage 13: channel level
	lumsh_pkg::post_t pp_s13;
	logic [18:0]      v_c [lumsh_pkg::NUM_CH];
	logic [18:0]      v_s13 [lumsh_pkg::NUM_CH];

	always_comb begin
		for (int c = 0; c < lumsh_pkg::NUM_CH; c++) begin
			case (sel_s12[c])
				lumsh_pkg::SEL_UP,
				lumsh_pkg::SEL_DOWN: v_c[c] = 19'(pp_s12.m1) + q_s12[c];
				lumsh_pkg::SEL_HIGH: v_c[c] = 19'(pp_s12.m2);
				default:             v_c[c] = 19'(pp_s12.m1);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s13 <= pp_s12;
			v_s13  <= v_c;
		end
	end

	// stage 14: scale to 8 bits, output select
	logic [26:0] w_c [lumsh_pkg::NUM_CH];
	logic [7:0]  ch_c [lumsh_pkg::NUM_CH];
	logic [7:0]  red_s14, green_s14, blue_s14;
	logic        key_s14;

	always_comb begin
		for (int c = 0; c < lumsh_pkg::NUM_CH; c++) begin
			w_c[c]  = {v_s13[c], 8'b0} - 27'(v_s13[c]);
			ch_c[c] = (w_c[c][26:16] > 11'd255) ? 8'd255 : w_c[c][23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_s14 <= pp_s13.cmn.key;
			if (!pp_s13.cmn.mdfy) begin
				red_s14   <= pp_s13.cmn.r;
				green_s14 <= pp_s13.cmn.g;
				blue_s14  <= pp_s13.cmn.b;
			end else if (pp_s13.cmn.grey) begin
				red_s14   <= pp_s13.gry;
				green_s14 <= pp_s13.gry;
				blue_s14  <= pp_s13.gry;
			end else begin
				red_s14   <= ch_c[0];
				green_s14 <= ch_c[1];
				blue_s14  <= ch_c[2];
			end
		end
	end

	assign out_valid = vld_s[NST];
	assign red_out   = red_s14;
	assign green_out = green_s14;
	assign blue_out  = blue_s14;
	assign key_match = key_s14;

`ifndef SYNTH
	a_nl_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[2] |-> dp_s[0].nl <= lumsh_pkg::ONE_Q16)
		else $error("new lightness out of range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NDS+2] && !dp_s[NDS].cmn.grey) |->
		(dp_s[NDS].sa.rem < dp_s[NDS].den && dp_s[NDS].hb.rem < dp_s[NDS].dvs))
		else $error("divider remainder not below divisor");

	a_sat_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NDS+3] && !cmn_s9.grey) |->
		(sat_s9 != '0 && hue_s9 <= lumsh_pkg::DEG360))
		else $error("saturation or hue out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NST] && !out_ready) |=> $stable(vld_s))
		else $error("pipeline moved during output stall");
`endif

endmodule
